@@ rtl/sks_pkg.sv @@
// Shared types and constants for the solenoid kicker sequencer.
// No dependencies; every other file in rtl/ depends on this package.
package sks_pkg;

   localparam int CNT_W     = 16;
   localparam int PULSE_W   = 8;
   localparam int CODE_W    = 3;
   localparam int REQ_W     = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [CNT_W-1:0] CNT_MAX      = '1;
   localparam logic [CNT_W-1:0] WINDOW_RESET = 16'd1000;

   // request codes
   localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_CHARGE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_KICK   = 2'd2;
   localparam logic [REQ_W-1:0] REQ_FORCE  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RECHARGE_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARGE_DURATION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ARMED_WINDOW    = 2'd2;

   // reported state codes
   localparam logic [CODE_W-1:0] CODE_IDLE     = 3'd0;
   localparam logic [CODE_W-1:0] CODE_CHARGING = 3'd1;
   localparam logic [CODE_W-1:0] CODE_CHARGED  = 3'd2;
   localparam logic [CODE_W-1:0] CODE_WAITING  = 3'd3;
   localparam logic [CODE_W-1:0] CODE_KICKING  = 3'd4;

   typedef enum logic [4:0] {
      MODE_IDLE     = 5'b00001,
      MODE_CHARGING = 5'b00010,
      MODE_CHARGED  = 5'b00100,
      MODE_WAITING  = 5'b01000,
      MODE_KICKING  = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [CNT_W-1:0] recharge_window;
      logic [CNT_W-1:0] charge_duration;
      logic [CNT_W-1:0] armed_window;
   } sks_cfg_type;

   typedef struct packed {
      mode_type           mode;
      logic               charge_seen;
      logic [CNT_W-1:0]   since_charge_cmd;
      logic [CNT_W-1:0]   since_charge_start;
      logic               armed_flag;
      logic [CNT_W-1:0]   since_armed;
      logic [PULSE_W-1:0] pulse_length;
      logic               force_pending;
      logic [PULSE_W-1:0] pulse_left;
      logic               charge_level;
   } sks_state_type;

   typedef struct packed {
      logic [REQ_W-1:0]   req_type;
      logic [PULSE_W-1:0] kick_time;
      logic               ball_ready;
   } sks_item_type;

   typedef struct packed {
      logic [CODE_W-1:0] state_code;
      logic              charge_on;
      logic              kick_on;
      logic              kick_fired;
   } sks_result_type;

   function automatic logic [CODE_W-1:0] mode_code(input mode_type m);
      logic [CODE_W-1:0] code;
      case (m)
         MODE_CHARGING: code = CODE_CHARGING;
         MODE_CHARGED:  code = CODE_CHARGED;
         MODE_WAITING:  code = CODE_WAITING;
         MODE_KICKING:  code = CODE_KICKING;
         default:       code = CODE_IDLE;
      endcase
      return code;
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

endpackage

@@ rtl/sks_if.sv @@
// Valid/ready channel interfaces: request, response and register write.
// Depends on sks_pkg for field widths.
interface sks_req_if;
   logic                          valid;
   logic                          ready;
   logic [sks_pkg::REQ_W-1:0]     req_type;
   logic [sks_pkg::PULSE_W-1:0]   kick_time;
   logic                          ball_ready;

   modport source (output valid, output req_type, output kick_time, output ball_ready,
                   input ready);
   modport sink   (input valid, input req_type, input kick_time, input ball_ready,
                   output ready);
endinterface

interface sks_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sks_pkg::CODE_W-1:0]    state_code;
   logic                          charge_on;
   logic                          kick_on;
   logic                          kick_fired;

   modport source (output valid, output state_code, output charge_on, output kick_on,
                   output kick_fired, input ready);
   modport sink   (input valid, input state_code, input charge_on, input kick_on,
                   input kick_fired, output ready);
endinterface

interface sks_csr_if;
   logic                          valid;
   logic                          ready;
   logic [sks_pkg::CSR_IDX_W-1:0] index;
   logic [sks_pkg::CNT_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/sks_core.sv @@
// Next-state and result logic of the kicker sequencer for one item.
// Depends on sks_pkg; purely combinational, registered by the top level.
module sks_core (
   input  sks_pkg::sks_cfg_type    cfg,
   input  sks_pkg::sks_state_type  cur,
   input  sks_pkg::sks_item_type   item,
   output sks_pkg::sks_state_type  nxt,
   output sks_pkg::sks_result_type result
);
   import sks_pkg::*;

   logic [CNT_W-1:0]   cmd_inc;
   logic [CNT_W-1:0]   start_inc;
   logic [CNT_W-1:0]   armed_inc;
   logic [PULSE_W-1:0] pulse_dec;
   logic               recharge_to;
   logic               armed_now;
   logic               fired;

   // elapsed counters as advanced by a tick
   assign cmd_inc   = sat_inc(cur.since_charge_cmd);
   assign start_inc = sat_inc(cur.since_charge_start);
   assign armed_inc = sat_inc(cur.since_armed);
   assign pulse_dec = (cur.pulse_left != '0) ? cur.pulse_left - 1'b1 : cur.pulse_left;

   assign recharge_to = !cur.charge_seen || (cmd_inc > cfg.recharge_window);
   assign armed_now   = cur.armed_flag && (armed_inc < cfg.armed_window);

   always_comb begin
      nxt   = cur;
      fired = 1'b0;
      case (item.req_type)
         REQ_CHARGE: begin
            nxt.charge_seen      = 1'b1;
            nxt.since_charge_cmd = '0;
         end
         REQ_KICK, REQ_FORCE: begin
            nxt.charge_seen      = 1'b1;
            nxt.since_charge_cmd = '0;
            nxt.armed_flag       = 1'b1;
            nxt.since_armed      = '0;
            nxt.pulse_length     = item.kick_time;
            if (item.req_type == REQ_FORCE) begin
               nxt.force_pending = 1'b1;
            end
         end
         default: begin
            nxt.since_charge_cmd   = cmd_inc;
            nxt.since_charge_start = start_inc;
            nxt.since_armed        = armed_inc;
            nxt.pulse_left         = pulse_dec;
            case (cur.mode)
               MODE_CHARGING: begin
                  if (!recharge_to) begin
                     nxt.charge_level = 1'b1;
                     if (start_inc > cfg.charge_duration) begin
                        nxt.mode = MODE_CHARGED;
                     end
                  end
               end
               MODE_CHARGED: begin
                  if (armed_now) begin
                     nxt.mode = MODE_WAITING;
                  end else if (recharge_to) begin
                     nxt.mode = MODE_IDLE;
                  end
               end
               MODE_WAITING: begin
                  if (item.ball_ready || cur.force_pending) begin
                     nxt.charge_level  = 1'b0;
                     nxt.mode          = MODE_KICKING;
                     nxt.pulse_left    = cur.pulse_length;
                     nxt.force_pending = 1'b0;
                     fired             = 1'b1;
                  end else if (!armed_now) begin
                     nxt.mode = MODE_IDLE;
                  end
               end
               MODE_KICKING: begin
                  if (pulse_dec == '0) begin
                     nxt.mode       = MODE_IDLE;
                     nxt.armed_flag = 1'b0;
                  end
               end
               default: begin
                  nxt.charge_level       = 1'b0;
                  nxt.mode               = MODE_CHARGING;
                  nxt.since_charge_start = '0;
               end
            endcase
         end
      endcase
   end

   assign result.state_code = mode_code(nxt.mode);
   assign result.charge_on  = nxt.charge_level;
   assign result.kick_on    = (nxt.pulse_left != '0);
   assign result.kick_fired = fired;

endmodule

@@ rtl/solenoid_kicker_sequencer_unit.sv @@
// Top level of the solenoid kicker sequencer: input register, sequencing
// logic (sks_core) and response register. Depends on sks_pkg, sks_if, sks_core.
//
// Use:
//   req_bus carries one item per transfer: a 1 ms tick, a charge command,
//   a kick command or a forced kick, with pulse length and ball sensor level.
//   rsp_bus returns exactly one result per request, in order: the mode code,
//   charge output level, solenoid pulse level and a fired flag.
//   csr_bus writes the three window registers (index 0 recharge window,
//   1 charge duration, 2 armed window); ready is always high, unknown
//   indexes are dropped. Write only while no request is in flight.
// Timing:
//   A request transfer lands in the input register; from there it runs
//   through the sequencing logic into the response register once that is
//   empty or being taken, and the result is offered from there. One item per
//   cycle is sustained while rsp_bus keeps taking: the input register advances
//   whenever the response register is empty or being taken in the same cycle.
// Stall:
//   With rsp_bus stalled the block holds up to two items (one in each
//   register) and then drops req_bus.ready until the response is taken.
// Reset:
//   Synchronous, active high. Clears both valid flags, sets the sequencer to
//   idle with all counters and flags zero, and the three registers to 1000.
module solenoid_kicker_sequencer_unit (
   input logic         clock,
   input logic         reset,
   sks_req_if.sink     req_bus,
   sks_rsp_if.source   rsp_bus,
   sks_csr_if.sink     csr_bus
);
   import sks_pkg::*;

   sks_cfg_type    cfg_ff,   cfg_in;
   sks_state_type  state_ff, state_in;
   sks_item_type   item_ff,  item_in;
   logic           item_valid_ff, item_valid_in;
   sks_result_type rsp_ff,   rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;

   sks_state_type  core_nxt;
   sks_result_type core_result;
   logic           advance;
   logic           req_take;

   // move the held item into the response register when that frees up
   assign advance  = item_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !item_valid_ff || advance;
   assign req_take = req_bus.valid && req_bus.ready;

   assign csr_bus.ready = 1'b1;

   sks_core u_core (
      .cfg    (cfg_ff),
      .cur    (state_ff),
      .item   (item_ff),
      .nxt    (core_nxt),
      .result (core_result)
   );

   always_comb begin
      // register writes
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_RECHARGE_WINDOW: cfg_in.recharge_window = csr_bus.data;
            CSR_CHARGE_DURATION: cfg_in.charge_duration = csr_bus.data;
            CSR_ARMED_WINDOW:    cfg_in.armed_window    = csr_bus.data;
            default:             cfg_in = cfg_ff;
         endcase
      end

      // input register: load on transfer, drop once advanced
      item_in       = item_ff;
      item_valid_in = item_valid_ff && !advance;
      if (req_take) begin
         item_in.req_type   = req_bus.req_type;
         item_in.kick_time  = req_bus.kick_time;
         item_in.ball_ready = req_bus.ball_ready;
         item_valid_in      = 1'b1;
      end

      // sequencer state commits only when its result is captured
      state_in = advance ? core_nxt : state_ff;

      // response register
      rsp_in       = advance ? core_result : rsp_ff;
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.recharge_window   <= WINDOW_RESET;
         cfg_ff.charge_duration   <= WINDOW_RESET;
         cfg_ff.armed_window      <= WINDOW_RESET;
         state_ff.mode               <= MODE_IDLE;
         state_ff.charge_seen        <= 1'b0;
         state_ff.since_charge_cmd   <= '0;
         state_ff.since_charge_start <= '0;
         state_ff.armed_flag         <= 1'b0;
         state_ff.since_armed        <= '0;
         state_ff.pulse_length       <= '0;
         state_ff.force_pending      <= 1'b0;
         state_ff.pulse_left         <= '0;
         state_ff.charge_level       <= 1'b0;
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         state_ff      <= state_in;
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.state_code = rsp_ff.state_code;
   assign rsp_bus.charge_on  = rsp_ff.charge_on;
   assign rsp_bus.kick_on    = rsp_ff.kick_on;
   assign rsp_bus.kick_fired = rsp_ff.kick_fired;

endmodule

@@ rtl/sks_checker.sv @@
// Port-level assertions for the kicker sequencer, bound to the top level.
// Depends on sks_pkg and solenoid_kicker_sequencer_unit.
module sks_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [sks_pkg::CODE_W-1:0]  rsp_state_code,
   input logic                        rsp_charge_on,
   input logic                        rsp_kick_on,
   input logic                        rsp_kick_fired
);
   import sks_pkg::*;

   // hold an offered response until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   // nothing is offered straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a fired kick enters kicking with the charge bank off
   a_fire_kicking: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kick_fired |-> rsp_state_code == CODE_KICKING && !rsp_charge_on)
      else $error("kick fired outside kicking or with charge on");

   // the solenoid is only driven while kicking
   a_pulse_kicking: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kick_on |-> rsp_state_code == CODE_KICKING)
      else $error("solenoid pulse outside kicking");

endmodule

bind solenoid_kicker_sequencer_unit sks_checker u_sks_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_state_code (rsp_bus.state_code),
   .rsp_charge_on  (rsp_bus.charge_on),
   .rsp_kick_on    (rsp_bus.kick_on),
   .rsp_kick_fired (rsp_bus.kick_fired)
);

@@ verif/tb_solenoid_kicker_sequencer_unit.sv @@
// Self-checking bench for solenoid_kicker_sequencer_unit: directed and random
// commands and ticks, with a behavioural predictor scoring every response.
// Depends on rtl/sks_pkg.sv, rtl/sks_if.sv and the unit itself.
module tb_solenoid_kicker_sequencer_unit;
   import sks_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int REPORT_LIMIT   = 10;
   localparam int PHASE_ITEMS    = 100;
   localparam int PHASE_COUNT    = 14;

   // index 3 decodes to no register: writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      STIM_ITEM,
      STIM_CSR,
      STIM_SYNC
   } stim_kind_type;

   typedef struct {
      stim_kind_type         kind;
      sks_item_type          item;
      logic [CSR_IDX_W-1:0]  index;
      logic [CNT_W-1:0]      data;
   } stim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sks_req_if req_bus ();
   sks_rsp_if rsp_bus ();
   sks_csr_if csr_bus ();

   solenoid_kicker_sequencer_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // pending transfers, filled up front and drained by the driver
   stim_type       pending_stim[$];
   // responses the sequencer owes us, oldest first
   sks_result_type owed_results[$];

   // handshake seen at the last rising edge, read by the driver at the falling one
   logic req_fire = 1'b0;
   logic csr_fire = 1'b0;

   int fail_count  = 0;
   int idle_cycles = 0;

   // sender burst shaping
   int burst_left = 1;
   int gap_left   = 0;

   // receiver stall pattern
   logic [15:0] stall_bits = '1;
   logic [3:0]  stall_pos  = '0;

   // predictor copy of the window registers and the sequencer state
   sks_cfg_type        win_cfg;
   mode_type           kick_mode;
   logic               charge_seen;
   logic [CNT_W-1:0]   since_charge_cmd;
   logic [CNT_W-1:0]   since_charge_start;
   logic               armed_flag;
   logic [CNT_W-1:0]   since_armed;
   logic [PULSE_W-1:0] pulse_length;
   logic               force_pending;
   logic [PULSE_W-1:0] pulse_left;
   logic               charge_level;

   always #5 clock = ~clock;

   // Advance the predicted sequencer by one transfer and return its response.
   function automatic sks_result_type predict_kicker(input sks_item_type it);
      sks_result_type res;
      logic           fired;
      logic           recharge_out;
      logic           armed_now;
      fired = 1'b0;
      case (it.req_type)
         REQ_CHARGE: begin
            charge_seen      = 1'b1;
            since_charge_cmd = '0;
         end
         REQ_KICK, REQ_FORCE: begin
            // a kick also counts as a charge request and arms the kicker
            charge_seen      = 1'b1;
            since_charge_cmd = '0;
            armed_flag       = 1'b1;
            since_armed      = '0;
            pulse_length     = it.kick_time;
            if (it.req_type == REQ_FORCE) begin
               force_pending = 1'b1;
            end
         end
         default: begin
            // tick: saturate the elapsed counters, then count the pulse down
            if (since_charge_cmd != CNT_MAX) since_charge_cmd++;
            if (since_charge_start != CNT_MAX) since_charge_start++;
            if (since_armed != CNT_MAX) since_armed++;
            if (pulse_left != '0) pulse_left--;
            recharge_out = !charge_seen || (since_charge_cmd > win_cfg.recharge_window);
            armed_now    = armed_flag && (since_armed < win_cfg.armed_window);
            case (kick_mode)
               MODE_CHARGING: begin
                  if (!recharge_out) begin
                     charge_level = 1'b1;
                     if (since_charge_start > win_cfg.charge_duration) begin
                        kick_mode = MODE_CHARGED;
                     end
                  end
               end
               MODE_CHARGED: begin
                  // charge level is left as it was here
                  if (recharge_out) kick_mode = MODE_IDLE;
                  if (armed_now) kick_mode = MODE_WAITING;
               end
               MODE_WAITING: begin
                  if (it.ball_ready || force_pending) begin
                     charge_level  = 1'b0;
                     kick_mode     = MODE_KICKING;
                     pulse_left    = pulse_length;
                     force_pending = 1'b0;
                     fired         = 1'b1;
                  end else if (!armed_now) begin
                     kick_mode = MODE_IDLE;
                  end
               end
               MODE_KICKING: begin
                  if (pulse_left == '0) begin
                     kick_mode  = MODE_IDLE;
                     armed_flag = 1'b0;
                  end
               end
               default: begin
                  charge_level       = 1'b0;
                  kick_mode          = MODE_CHARGING;
                  since_charge_start = '0;
               end
            endcase
         end
      endcase
      case (kick_mode)
         MODE_CHARGING: res.state_code = CODE_CHARGING;
         MODE_CHARGED:  res.state_code = CODE_CHARGED;
         MODE_WAITING:  res.state_code = CODE_WAITING;
         MODE_KICKING:  res.state_code = CODE_KICKING;
         default:       res.state_code = CODE_IDLE;
      endcase
      res.charge_on  = charge_level;
      res.kick_on    = (pulse_left != '0);
      res.kick_fired = fired;
      return res;
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%0t mismatch: %s", $realtime, msg);
      end
   endtask

   task automatic push_item(input logic [REQ_W-1:0] kind, input logic [PULSE_W-1:0] len,
                            input logic ball);
      stim_type s;
      s.kind           = STIM_ITEM;
      s.item.req_type  = kind;
      s.item.kick_time = len;
      s.item.ball_ready = ball;
      s.index          = '0;
      s.data           = '0;
      pending_stim.push_back(s);
   endtask

   task automatic push_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CNT_W-1:0] value);
      stim_type s;
      s.kind  = STIM_CSR;
      s.item  = '0;
      s.index = idx;
      s.data  = value;
      pending_stim.push_back(s);
   endtask

   // Hold the driver until every owed response has come back.
   task automatic push_sync();
      stim_type s;
      s.kind  = STIM_SYNC;
      s.item  = '0;
      s.index = '0;
      s.data  = '0;
      pending_stim.push_back(s);
   endtask

   // Mostly ticks with the odd command; short pulses dominate so kicks finish.
   task automatic push_random_item();
      logic [REQ_W-1:0]   kind;
      logic [PULSE_W-1:0] len;
      int                 pick;
      pick = $urandom_range(0, 99);
      if (pick < 78)      kind = REQ_TICK;
      else if (pick < 86) kind = REQ_CHARGE;
      else if (pick < 93) kind = REQ_KICK;
      else                kind = REQ_FORCE;
      pick = $urandom_range(0, 9);
      if (pick < 6)       len = PULSE_W'($urandom_range(0, 4));
      else if (pick == 9) len = '1;
      else                len = PULSE_W'($urandom);
      push_item(kind, len, $urandom_range(0, 9) < 3);
   endtask

   // Pick a window value: usually short, now and then an extreme.
   function automatic logic [CNT_W-1:0] pick_window();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(0, 1) ? CNT_MAX : '0;
      end
      return CNT_W'($urandom_range(0, 12));
   endfunction

   // Drive the request and register channels; inputs change on the falling edge.
   always @(negedge clock) begin : driver
      logic     offer_item;
      logic     offer_csr;
      stim_type head;
      if (reset) begin
         req_bus.valid <= 1'b0;
         csr_bus.valid <= 1'b0;
      end else if ((req_bus.valid && !req_fire) || (csr_bus.valid && !csr_fire)) begin
         // hold the current transfer until it is taken
      end else begin
         offer_item = 1'b0;
         offer_csr  = 1'b0;
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_stim.size() != 0) begin
            head = pending_stim[0];
            case (head.kind)
               STIM_ITEM: begin
                  offer_item = 1'b1;
                  void'(pending_stim.pop_front());
                  req_bus.req_type   <= head.item.req_type;
                  req_bus.kick_time  <= head.item.kick_time;
                  req_bus.ball_ready <= head.item.ball_ready;
                  // close the burst and draw the next gap
                  if (burst_left <= 1) begin
                     burst_left <= $urandom_range(1, 40);
                     gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                  end else begin
                     burst_left <= burst_left - 1;
                  end
               end
               STIM_CSR: begin
                  offer_csr = 1'b1;
                  void'(pending_stim.pop_front());
                  csr_bus.index <= head.index;
                  csr_bus.data  <= head.data;
               end
               default: begin
                  if (owed_results.size() == 0) begin
                     void'(pending_stim.pop_front());
                  end
               end
            endcase
         end
         req_bus.valid <= offer_item;
         csr_bus.valid <= offer_csr;
      end
   end

   // Stall the response channel on a 16-bit pattern, redrawn each time it has been stepped through.
   always @(negedge clock) begin : receiver
      logic [15:0] bits;
      bits = stall_bits;
      if (stall_pos == '1) begin
         bits = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
         stall_bits <= bits;
      end
      stall_pos     <= stall_pos + 1'b1;
      rsp_bus.ready <= bits[stall_pos + 1'b1];
   end

   // Sample every channel at the rising edge: apply register writes, score
   // responses against the oldest prediction, then predict the new transfer.
   always @(posedge clock) begin : monitor
      sks_item_type   taken;
      sks_result_type seen;
      sks_result_type want;
      if (reset) begin
         req_fire                <= 1'b0;
         csr_fire                <= 1'b0;
         win_cfg.recharge_window  = WINDOW_RESET;
         win_cfg.charge_duration  = WINDOW_RESET;
         win_cfg.armed_window     = WINDOW_RESET;
         kick_mode                = MODE_IDLE;
         charge_seen              = 1'b0;
         since_charge_cmd         = '0;
         since_charge_start       = '0;
         armed_flag               = 1'b0;
         since_armed              = '0;
         pulse_length             = '0;
         force_pending            = 1'b0;
         pulse_left               = '0;
         charge_level             = 1'b0;
      end else begin
         req_fire <= req_bus.valid && req_bus.ready;
         csr_fire <= csr_bus.valid && csr_bus.ready;
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_RECHARGE_WINDOW: win_cfg.recharge_window = csr_bus.data;
               CSR_CHARGE_DURATION: win_cfg.charge_duration = csr_bus.data;
               CSR_ARMED_WINDOW:    win_cfg.armed_window    = csr_bus.data;
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.state_code = rsp_bus.state_code;
            seen.charge_on  = rsp_bus.charge_on;
            seen.kick_on    = rsp_bus.kick_on;
            seen.kick_fired = rsp_bus.kick_fired;
            if (owed_results.size() == 0) begin
               note_failure($sformatf("response with nothing owed: code %0d charge %b kick %b fired %b",
                                      seen.state_code, seen.charge_on, seen.kick_on,
                                      seen.kick_fired));
            end else begin
               want = owed_results.pop_front();
               if (seen.state_code !== want.state_code || seen.charge_on !== want.charge_on ||
                   seen.kick_on !== want.kick_on || seen.kick_fired !== want.kick_fired) begin
                  note_failure($sformatf(
                     "expected code %0d charge %b kick %b fired %b, got %0d %b %b %b",
                     want.state_code, want.charge_on, want.kick_on, want.kick_fired,
                     seen.state_code, seen.charge_on, seen.kick_on, seen.kick_fired));
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            taken.req_type   = req_bus.req_type;
            taken.kick_time  = req_bus.kick_time;
            taken.ball_ready = req_bus.ball_ready;
            owed_results.push_back(predict_kicker(taken));
         end
      end
   end

   // End the run once nothing has moved on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.req_type   = REQ_TICK;
      req_bus.kick_time  = '0;
      req_bus.ball_ready = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = CSR_RECHARGE_WINDOW;
      csr_bus.data       = '0;
      rsp_bus.ready      = 1'b1;

      // Directed walk with short windows: one full charge, kick and forced kick.
      push_csr(CSR_RECHARGE_WINDOW, 16'd4);
      push_csr(CSR_CHARGE_DURATION, 16'd2);
      push_csr(CSR_ARMED_WINDOW, 16'd6);
      push_item(REQ_TICK, 8'd0, 1'b0);       // idle to charging
      push_item(REQ_TICK, 8'd0, 1'b1);       // no charge request yet: nothing moves
      push_item(REQ_CHARGE, 8'hFF, 1'b1);    // command: outputs untouched
      push_item(REQ_TICK, 8'd0, 1'b0);       // charge output on
      push_item(REQ_TICK, 8'd0, 1'b0);       // charge duration passed
      push_item(REQ_TICK, 8'd0, 1'b1);       // charged keeps its level, not armed
      push_item(REQ_KICK, 8'd0, 1'b0);       // zero pulse length
      push_item(REQ_TICK, 8'd0, 1'b0);       // armed: waiting for ball
      push_item(REQ_TICK, 8'd0, 1'b1);       // fires with no pulse
      push_item(REQ_TICK, 8'd0, 1'b0);       // leaves kicking straight away
      push_item(REQ_TICK, 8'hFF, 1'b0);
      push_item(REQ_FORCE, 8'd2, 1'b0);
      push_item(REQ_TICK, 8'd0, 1'b0);
      push_item(REQ_TICK, 8'd0, 1'b0);
      push_item(REQ_TICK, 8'd0, 1'b0);
      push_item(REQ_TICK, 8'd0, 1'b0);
      push_item(REQ_TICK, 8'd0, 1'b0);       // force fires without the ball
      push_item(REQ_TICK, 8'd0, 1'b0);
      push_item(REQ_TICK, 8'd0, 1'b0);       // pulse ends, back to idle
      push_item(REQ_TICK, 8'd0, 1'b0);
      push_item(REQ_TICK, 8'd0, 1'b1);       // recharge window expired while charging

      // Random phases, each under a fresh set of windows.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         push_sync();
         if ($urandom_range(0, 2) == 0) begin
            push_csr(CSR_UNUSED, 16'($urandom));
         end
         if (phase == 0) begin
            push_csr(CSR_RECHARGE_WINDOW, '0);
            push_csr(CSR_CHARGE_DURATION, '0);
            push_csr(CSR_ARMED_WINDOW, '0);
         end else if (phase == 1) begin
            push_csr(CSR_RECHARGE_WINDOW, CNT_MAX);
            push_csr(CSR_CHARGE_DURATION, CNT_MAX);
            push_csr(CSR_ARMED_WINDOW, CNT_MAX);
         end else if (phase == 2) begin
            // recharge and charge windows one short of full scale, armed window full, opened by a charge request
            push_csr(CSR_RECHARGE_WINDOW, CNT_MAX - 1'b1);
            push_csr(CSR_CHARGE_DURATION, CNT_MAX - 1'b1);
            push_csr(CSR_ARMED_WINDOW, CNT_MAX);
            push_item(REQ_CHARGE, PULSE_W'($urandom), 1'b0);
         end else begin
            push_csr(CSR_RECHARGE_WINDOW, pick_window());
            push_csr(CSR_CHARGE_DURATION, pick_window());
            push_csr(CSR_ARMED_WINDOW, pick_window());
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            push_random_item();
         end
      end

      // release reset on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      @(posedge clock);
      while (pending_stim.size() != 0 || req_bus.valid || csr_bus.valid ||
             owed_results.size() != 0) begin
         @(posedge clock);
      end
      // allow the pipeline to show any stray response
      repeat (8) @(posedge clock);
      if (fail_count == 0 && owed_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ solenoid_kicker_sequencer_unit.f @@
rtl/sks_pkg.sv
rtl/sks_if.sv
rtl/sks_core.sv
rtl/solenoid_kicker_sequencer_unit.sv
rtl/sks_checker.sv
verif/tb_solenoid_kicker_sequencer_unit.sv
